// File: hw/rtl/oaps_pkg.sv
package oaps_pkg;

  localparam int unsigned KEY_FIELD_W       = 64;
  localparam int unsigned STATUS_W          = 3;
  localparam int unsigned COUNT_W           = 12;
  localparam int unsigned SHIFT_W           = 3;
  localparam int unsigned DEF_TABLE_SIZE    = 2048;
  localparam int unsigned DEF_KEY_WIDTH     = 64;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_e;

endpackage

// File: hw/rtl/oaps_req_if.sv
interface oaps_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [oaps_pkg::KEY_FIELD_W-1:0]   key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// File: hw/rtl/oaps_rsp_if.sv
interface oaps_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [oaps_pkg::STATUS_W-1:0]   status;
  logic [oaps_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// File: hw/rtl/open_address_pointer_set.sv
// Open-addressing set of pointer keys with triangular probing, held in a single
// synchronous slot memory of TABLE_SIZE entries. After reset the block clears
// the memory, one slot a cycle, and accepts no request meanwhile; writes to
// the shift register are taken at any time. A request then passes through the
// probe walk, which examines one slot for each read of the slot memory and
// issues one read per cycle; the next probe address depends on the data
// returned. The completion state then places the result in the output
// register once it is free. The next request is accepted while a result
// still waits in the output register.
module open_address_pointer_set_core #(
  parameter int unsigned TABLE_SIZE = oaps_pkg::DEF_TABLE_SIZE,
  parameter int unsigned KEY_WIDTH  = oaps_pkg::DEF_KEY_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [oaps_pkg::SHIFT_W-1:0]  cfg_wdata_i,
  oaps_req_if.sink                      req_i,
  oaps_rsp_if.source                    rsp_o
);
  import oaps_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] MASK = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [SHIFT_W-1:0]     shift_q;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       step_q, step_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic                   lookup_q, lookup_d;
  status_e                res_q, res_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]    rsp_status_q, rsp_status_d;
  logic [COUNT_W-1:0]     rsp_count_q, rsp_count_d;

  logic [KEY_WIDTH-1:0]   slot_mem_q [TABLE_SIZE];
  logic [KEY_WIDTH-1:0]   rdata_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [KEY_WIDTH-1:0]   mem_wdata;

  logic [KEY_WIDTH-1:0]   key_in;
  logic [KEY_FIELD_W-1:0] key_shifted;
  logic [IDX_W-1:0]       home;
  logic [IDX_W-1:0]       step_n;
  logic                   req_fire;
  logic                   rsp_free;

  assign key_in      = req_i.key[KEY_WIDTH-1:0];
  assign key_shifted = KEY_FIELD_W'(key_in) >> shift_q;
  assign home        = key_shifted[IDX_W-1:0] & MASK;
  assign step_n      = step_q + 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    step_d       = step_q;
    key_d        = key_q;
    lookup_d     = lookup_q;
    res_d        = res_q;
    count_d      = count_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = '0;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          key_d    = key_in;
          lookup_d = req_i.req_type;
          idx_d    = home;
          step_d   = '0;
          if (key_in == '0) begin
            res_d   = ST_ZERO_KEY;
            state_d = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (rdata_q == key_q) begin
          res_d   = lookup_q ? ST_FOUND : ST_PRESENT;
          state_d = S_DONE;
        end else if (rdata_q == '0) begin
          if (lookup_q) begin
            res_d = ST_NOT_FOUND;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = key_q;
            count_d   = count_q + 1'b1;
            res_d     = ST_INSERTED;
          end
          state_d = S_DONE;
        end else if (step_q == MASK) begin
          res_d   = lookup_q ? ST_NOT_FOUND : ST_FULL;
          state_d = S_DONE;
        end else begin
          step_d = step_n;
          idx_d  = (idx_q + step_n) & MASK;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_q;
          rsp_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      shift_q     <= SHIFT_RESET;
      idx_q       <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    key_q        <= key_d;
    lookup_q     <= lookup_d;
    res_q        <= res_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  // A lookup must never write a key into the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_PROBE) |-> !lookup_q)
    else $error("slot written during a lookup");

  // The entry count only ever grows by one per request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count moved by more than one");

  // A zero key is never probed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (key_q != '0))
    else $error("zero key entered the probe walk");

  // A new result appears only on leaving the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> ($past(state_q) == S_DONE))
    else $error("result issued outside the completion state");

endmodule
